[design/command_frame_deframer_core_macros.svh]
// assertion macros shared by the deframer checker
// no dependencies
`ifndef COMMAND_FRAME_DEFRAMER_CORE_MACROS_SVH
`define COMMAND_FRAME_DEFRAMER_CORE_MACROS_SVH

// clocked assertion with reset disable
`define CFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked assertion that also holds through reset
`define CFD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

[design/cfd_pkg.sv]
// shared types, codes and constants for the command frame deframer
// no dependencies
package cfd_pkg;

   localparam int BYTE_W    = 8;
   localparam int RIDX_W    = 10;
   localparam int EVENT_W   = 3;
   localparam int LEN_W     = 11;
   localparam int FLEN_W    = 16;
   localparam int PREFIX_LEN = 6;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 11;

   localparam logic ACT_RX   = 1'b0;
   localparam logic ACT_READ = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 1'b1;

   localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
   localparam logic [EVENT_W-1:0] EV_START  = 3'd1;
   localparam logic [EVENT_W-1:0] EV_STOP   = 3'd2;
   localparam logic [EVENT_W-1:0] EV_RETURN = 3'd3;
   localparam logic [EVENT_W-1:0] EV_RC     = 3'd4;
   localparam logic [EVENT_W-1:0] EV_PATH   = 3'd5;

   localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'h3E;
   localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 11'd1024;
   localparam logic [BYTE_W-1:0] PREFIX_RST      = 8'hFF;

   typedef logic [PREFIX_LEN-1:0][BYTE_W-1:0] prefix_type;

   function automatic logic [EVENT_W-1:0] classify(input prefix_type p);
      logic [EVENT_W-1:0] ev;
      if ({p[0], p[1], p[2], p[3], p[4]} == "START") begin
         ev = EV_START;
      end else if ({p[0], p[1], p[2], p[3]} == "STOP") begin
         ev = EV_STOP;
      end else if ({p[0], p[1], p[2], p[3], p[4], p[5]} == "RETURN") begin
         ev = EV_RETURN;
      end else if ({p[0], p[1]} == "RC") begin
         ev = EV_RC;
      end else begin
         ev = EV_PATH;
      end
      return ev;
   endfunction

endpackage

[design/cfd_if.sv]
// valid/ready channels for deframer requests and responses
// depends on cfd_pkg
interface cfd_req_if;
   import cfd_pkg::*;
   logic                valid;
   logic                ready;
   logic                action;
   logic [BYTE_W-1:0]   rx_byte;
   logic [RIDX_W-1:0]   read_index;
   modport source (output valid, action, rx_byte, read_index, input ready);
   modport sink   (input valid, action, rx_byte, read_index, output ready);
endinterface

interface cfd_rsp_if;
   import cfd_pkg::*;
   logic                valid;
   logic                ready;
   logic [EVENT_W-1:0]  event_code;
   logic [LEN_W-1:0]    payload_length;
   logic [BYTE_W-1:0]   read_data;
   modport source (output valid, event_code, payload_length, read_data, input ready);
   modport sink   (input valid, event_code, payload_length, read_data, output ready);
endinterface

[design/command_frame_deframer_core.sv]
// length-prefixed frame parser with payload ram and prefix classification
// depends on cfd_pkg and cfd_if
// Takes one request transaction per cycle while the response side is not
// stalled, a received byte or a read of the payload ram, and returns
// exactly one response transaction for each, passing the registered read
// of the single-port-per-direction payload ram and then the output
// register. Received bytes update the parser and write the ram
// in the accepting cycle, so a read right after a
// payload byte already sees it. A stalled response holds back at most one
// further request before req_chan.ready drops. No clearing pass: ram
// entries never written read back as undefined.
module command_frame_deframer_core #(
   parameter int BUFFER_DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   cfd_req_if.sink                          req_chan,
   cfd_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [cfd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cfd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import cfd_pkg::*;

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam logic [16:0] DEPTH_L = 17'(BUFFER_DEPTH);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;
   localparam logic [1:0] PH_SUM  = 2'd3;

   logic [BYTE_W-1:0]  start_byte_ff;
   logic [LEN_W-1:0]   max_payload_ff;
   logic [1:0]         phase_ff, phase_in;
   logic               high_seen_ff, high_seen_in;
   logic [FLEN_W-1:0]  frame_len_ff, frame_len_in;
   logic [AW-1:0]      byte_idx_ff, byte_idx_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   prefix_type         prefix_ff, prefix_in;

   logic               s1_valid_ff, s1_valid_in;
   logic [EVENT_W-1:0] s1_event_ff, s1_event_in;
   logic [LEN_W-1:0]   s1_len_ff, s1_len_in;
   logic               s1_read_ff, s1_read_in;
   logic [BYTE_W-1:0]  mem_q_ff;

   logic               out_valid_ff, out_valid_in;
   logic [EVENT_W-1:0] out_event_ff;
   logic [LEN_W-1:0]   out_len_ff;
   logic [BYTE_W-1:0]  out_data_ff;

   logic [BYTE_W-1:0]  store_mem [BUFFER_DEPTH];

   logic               s1_move;
   logic               accept;
   logic               rx_acc;
   logic               mem_we;
   logic               mem_re;
   logic [16:0]        limit;
   logic [FLEN_W-1:0]  len_full;

   assign s1_move = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_move;
   assign accept = req_chan.valid && req_chan.ready;
   assign rx_acc = accept && (req_chan.action == ACT_RX);
   assign mem_re = accept && (req_chan.action == ACT_READ);
   assign limit = (17'(max_payload_ff) < DEPTH_L) ? 17'(max_payload_ff) : DEPTH_L;
   assign len_full = {frame_len_ff[FLEN_W-1:8], req_chan.rx_byte};

   // parser next state
   always_comb begin
      phase_in     = phase_ff;
      high_seen_in = high_seen_ff;
      frame_len_in = frame_len_ff;
      byte_idx_in  = byte_idx_ff;
      sum_in       = sum_ff;
      prefix_in    = prefix_ff;
      mem_we       = 1'b0;
      s1_event_in  = EV_NONE;
      if (rx_acc) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (req_chan.rx_byte == start_byte_ff) begin
                  phase_in     = PH_LEN;
                  high_seen_in = 1'b0;
                  frame_len_in = '0;
                  byte_idx_in  = '0;
                  sum_in       = '0;
                  prefix_in    = {PREFIX_LEN{PREFIX_RST}};
               end
            end
            PH_LEN: begin
               if (!high_seen_ff) begin
                  frame_len_in = {req_chan.rx_byte, 8'h00};
                  high_seen_in = 1'b1;
               end else begin
                  frame_len_in = len_full;
                  high_seen_in = 1'b0;
                  if (17'(len_full) > limit) begin
                     phase_in = PH_IDLE;
                  end else if (len_full == '0) begin
                     phase_in = PH_SUM;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               mem_we = 17'(byte_idx_ff) < DEPTH_L;
               for (int i = 0; i < PREFIX_LEN; i++) begin
                  if (byte_idx_ff == AW'(i)) begin
                     prefix_in[i] = req_chan.rx_byte;
                  end
               end
               sum_in = sum_ff + req_chan.rx_byte;
               if (17'(byte_idx_ff) + 17'd1 >= 17'(frame_len_ff)) begin
                  phase_in = PH_SUM;
               end else begin
                  byte_idx_in = byte_idx_ff + AW'(1);
               end
            end
            PH_SUM: begin
               phase_in = PH_IDLE;
               if (sum_ff == req_chan.rx_byte) begin
                  s1_event_in = classify(prefix_ff);
               end
            end
         endcase
      end
   end

   // saturated length as seen after this transaction
   assign s1_len_in = (|frame_len_in[FLEN_W-1:LEN_W]) ? {LEN_W{1'b1}}
                                                       : frame_len_in[LEN_W-1:0];
   assign s1_read_in = mem_re && (17'(req_chan.read_index) < DEPTH_L);
   assign s1_valid_in = accept || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[byte_idx_ff] <= req_chan.rx_byte;
      end
      if (mem_re) begin
         mem_q_ff <= store_mem[AW'(req_chan.read_index)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff  <= START_BYTE_RST;
         max_payload_ff <= MAX_PAYLOAD_RST;
         phase_ff       <= PH_IDLE;
         high_seen_ff   <= 1'b0;
         frame_len_ff   <= '0;
         byte_idx_ff    <= '0;
         sum_ff         <= '0;
         prefix_ff      <= {PREFIX_LEN{PREFIX_RST}};
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_START_BYTE:  start_byte_ff  <= csr_wdata[BYTE_W-1:0];
               CSR_MAX_PAYLOAD: max_payload_ff <= csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
         phase_ff     <= phase_in;
         high_seen_ff <= high_seen_in;
         frame_len_ff <= frame_len_in;
         byte_idx_ff  <= byte_idx_in;
         sum_ff       <= sum_in;
         prefix_ff    <= prefix_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_event_ff <= s1_event_in;
         s1_len_ff   <= s1_len_in;
         s1_read_ff  <= s1_read_in;
      end
      if (s1_move) begin
         out_event_ff <= s1_event_ff;
         out_len_ff   <= s1_len_ff;
         out_data_ff  <= s1_read_ff ? mem_q_ff : '0;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.event_code     = out_event_ff;
   assign rsp_chan.payload_length = out_len_ff;
   assign rsp_chan.read_data      = out_data_ff;

endmodule

[design/cfd_checker.sv]
// port-level checks on the deframer response channel, bound to command_frame_deframer_core
// depends on cfd_pkg and the assertion macros header
`include "command_frame_deframer_core_macros.svh"

module cfd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [cfd_pkg::EVENT_W-1:0]    rsp_event_code,
   input logic [cfd_pkg::LEN_W-1:0]      rsp_payload_length,
   input logic [cfd_pkg::BYTE_W-1:0]     rsp_read_data
);
   import cfd_pkg::*;

   `CFD_ASSERT_ALWAYS(a_quiet_after_reset, clock, reset |=> !rsp_valid, "response valid after reset")
   `CFD_ASSERT(a_valid_held, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response valid dropped while stalled")
   `CFD_ASSERT(a_payload_held, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_event_code) && $stable(rsp_payload_length) && $stable(rsp_read_data), "stalled response changed")
   `CFD_ASSERT(a_event_range, clock, reset, rsp_valid |-> rsp_event_code <= EV_PATH, "event code out of range")
   `CFD_ASSERT(a_event_or_data, clock, reset, rsp_valid |-> rsp_event_code == EV_NONE || rsp_read_data == '0, "event and read data in one response")

endmodule

bind command_frame_deframer_core cfd_checker u_cfd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_event_code     (rsp_chan.event_code),
   .rsp_payload_length (rsp_chan.payload_length),
   .rsp_read_data      (rsp_chan.read_data)
);

[test/command_frame_deframer_core_tb.sv]
`timescale 1ns / 1ps
// testbench for command_frame_deframer_core: directed and random byte streams and reads,
// each response checked against a frame parser kept inside the bench
// depends on cfd_pkg, cfd_if and the core
module command_frame_deframer_core_tb;
   import cfd_pkg::*;

   localparam int STORE_DEPTH = 1024;

   typedef enum logic [1:0] {WAIT_START, GET_LENGTH, GET_PAYLOAD, GET_CHECKSUM}
      parse_state_type;
   typedef enum int {PFX_START, PFX_STOP, PFX_RETURN, PFX_RC, PFX_NEAR, PFX_RANDOM}
      prefix_kind_type;

   typedef struct packed {
      logic [EVENT_W-1:0] event_code;
      logic [LEN_W-1:0]   payload_length;
      logic [BYTE_W-1:0]  read_data;
   } deframer_rsp_type;

   class deframer_tracker;
      logic [BYTE_W-1:0] start_byte;
      logic [LEN_W-1:0]  max_payload;
      parse_state_type   state;
      bit                length_hi_seen;
      logic [FLEN_W-1:0] frame_len;
      int unsigned       byte_pos;
      logic [BYTE_W-1:0] payload_sum;
      logic [BYTE_W-1:0] prefix [PREFIX_LEN];
      logic [BYTE_W-1:0] store [STORE_DEPTH];
      int unsigned       filled;
      deframer_rsp_type  pending_rsp [$];
      int                failures;

      function new();
         start_byte = START_BYTE_RST;
         max_payload = MAX_PAYLOAD_RST;
         state = WAIT_START;
         length_hi_seen = 1'b0;
         frame_len = '0;
         byte_pos = 0;
         payload_sum = '0;
         foreach (prefix[i]) prefix[i] = PREFIX_RST;
         filled = 0;
         failures = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_START_BYTE:  start_byte = data[BYTE_W-1:0];
            CSR_MAX_PAYLOAD: max_payload = data[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [EVENT_W-1:0] frame_event();
         logic [8*PREFIX_LEN-1:0] p;
         p = {prefix[0], prefix[1], prefix[2], prefix[3], prefix[4], prefix[5]};
         if (p[47:8] == "START") return EV_START;
         if (p[47:16] == "STOP") return EV_STOP;
         if (p == "RETURN") return EV_RETURN;
         if (p[47:32] == "RC") return EV_RC;
         return EV_PATH;
      endfunction

      function void note_request(logic act, logic [BYTE_W-1:0] b, logic [RIDX_W-1:0] idx);
         deframer_rsp_type r;
         int unsigned limit;
         r = '0;
         if (act == ACT_READ) begin
            r.read_data = store[idx];
         end else begin
            case (state)
               WAIT_START: begin
                  if (b == start_byte) begin
                     state = GET_LENGTH;
                     length_hi_seen = 1'b0;
                     frame_len = '0;
                     byte_pos = 0;
                     payload_sum = '0;
                     foreach (prefix[i]) prefix[i] = PREFIX_RST;
                  end
               end
               GET_LENGTH: begin
                  if (!length_hi_seen) begin
                     frame_len = {b, 8'h00};
                     length_hi_seen = 1'b1;
                  end else begin
                     frame_len[7:0] = b;
                     length_hi_seen = 1'b0;
                     limit = (max_payload < STORE_DEPTH) ? max_payload : STORE_DEPTH;
                     if (frame_len > limit) state = WAIT_START;
                     else if (frame_len == 0) state = GET_CHECKSUM;
                     else state = GET_PAYLOAD;
                  end
               end
               GET_PAYLOAD: begin
                  store[byte_pos] = b;
                  if (byte_pos + 1 > filled) filled = byte_pos + 1;
                  if (byte_pos < PREFIX_LEN) prefix[byte_pos] = b;
                  payload_sum += b;
                  if (byte_pos + 1 >= frame_len) state = GET_CHECKSUM;
                  else byte_pos++;
               end
               default: begin
                  state = WAIT_START;
                  if (payload_sum == b) r.event_code = frame_event();
               end
            endcase
         end
         r.payload_length = (frame_len > {LEN_W{1'b1}}) ? {LEN_W{1'b1}} : frame_len[LEN_W-1:0];
         pending_rsp.push_back(r);
      endfunction

      function void report(string what, deframer_rsp_type want, deframer_rsp_type got);
         failures++;
         if (failures <= 10)
            $display("%0t %s: expected ev %0d len %0d data %h, got ev %0d len %0d data %h",
                     $time, what, want.event_code, want.payload_length, want.read_data,
                     got.event_code, got.payload_length, got.read_data);
      endfunction

      function void check_response(deframer_rsp_type got);
         deframer_rsp_type want;
         if (pending_rsp.size() == 0) begin
            report("unexpected transaction", '0, got);
            return;
         end
         want = pending_rsp.pop_front();
         if (got.event_code !== want.event_code || got.payload_length !== want.payload_length ||
             got.read_data !== want.read_data)
            report("mismatch", want, got);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    req_idle_pct = 10;
   int                    rsp_idle_pct = 10;
   int                    hold_left = 0;
   int                    useful_items = 0;
   deframer_tracker       tracker = new();

   cfd_req_if req_bus();
   cfd_rsp_if rsp_bus();

   command_frame_deframer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic send_req(input logic act, input logic [BYTE_W-1:0] b,
                           input logic [RIDX_W-1:0] idx);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= act;
      req_bus.rx_byte <= b;
      req_bus.read_index <= idx;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      tracker.note_request(act, b, idx);
      useful_items++;
   endtask

   // only entries already written are read back
   task automatic send_read();
      if (tracker.filled != 0)
         send_req(ACT_READ, BYTE_W'($urandom), RIDX_W'($urandom_range(0, tracker.filled - 1)));
   endtask

   task automatic send_frame(input int unsigned len, input prefix_kind_type kind,
                             input bit good_sum, input bit broken);
      logic [BYTE_W-1:0] frame_bytes [$];
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] b;
      string             word;
      bit                near;
      int unsigned       limit, pos, stop_at;
      near = (kind == PFX_NEAR);
      if (near) kind = prefix_kind_type'($urandom_range(PFX_START, PFX_RC));
      case (kind)
         PFX_START:  word = "START";
         PFX_STOP:   word = "STOP";
         PFX_RETURN: word = "RETURN";
         PFX_RC:     word = "RC";
         default:    word = "";
      endcase
      limit = (tracker.max_payload < STORE_DEPTH) ? tracker.max_payload : STORE_DEPTH;
      frame_bytes.push_back(tracker.start_byte);
      frame_bytes.push_back(len[15:8]);
      frame_bytes.push_back(len[7:0]);
      if (len <= limit) begin
         for (int i = 0; i < len; i++) begin
            if (i < word.len()) b = word[i];
            else b = BYTE_W'($urandom);
            frame_bytes.push_back(b);
         end
         if (near && len > 0) begin
            pos = $urandom_range(0, ((len < word.len()) ? len : word.len()) - 1);
            frame_bytes[3 + pos] ^= BYTE_W'(1) << $urandom_range(0, 7);
         end
         sum = '0;
         for (int i = 3; i < frame_bytes.size(); i++) sum += frame_bytes[i];
         if (!good_sum) sum ^= BYTE_W'(1) << $urandom_range(0, 7);
         frame_bytes.push_back(sum);
      end
      stop_at = broken ? $urandom_range(1, frame_bytes.size() - 1) : frame_bytes.size();
      for (int i = 0; i < stop_at; i++) begin
         if ($urandom_range(0, 99) < 8) send_read();
         send_req(ACT_RX, frame_bytes[i], RIDX_W'($urandom));
      end
   endtask

   task automatic run_traffic(input int target);
      int          goal;
      int unsigned limit, len, r;
      goal = useful_items + target;
      while (useful_items < goal) begin
         r = $urandom_range(0, 99);
         if (r < 6) begin
            send_req(ACT_RX, BYTE_W'($urandom), RIDX_W'($urandom));
            useful_items--;
         end else if (r < 16) begin
            send_read();
         end else begin
            limit = (tracker.max_payload < STORE_DEPTH) ? tracker.max_payload : STORE_DEPTH;
            r = $urandom_range(0, 99);
            if (r < 6) len = 0;
            else if (r < 72) len = $urandom_range(1, 12);
            else if (r < 88) len = $urandom_range(13, 48);
            else if (r < 94) len = limit + 1;
            else if (r < 97) len = $urandom_range(limit + 1, 16'hFFFF);
            else len = (limit <= 64) ? limit : $urandom_range(1, 12);
            send_frame(len, prefix_kind_type'($urandom_range(PFX_START, PFX_RANDOM)),
                       $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 5);
         end
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (tracker.pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_reg(idx, val[CSR_DATA_W-1:0]);
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            tracker.check_response({rsp_bus.event_code, rsp_bus.payload_length,
                                    rsp_bus.read_data});
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.action <= ACT_RX;
      req_bus.rx_byte <= '0;
      req_bus.read_index <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // zero length, oversize length, rc command, bad checksum, idle noise
      send_frame(0, PFX_RANDOM, 1'b1, 1'b0);
      send_frame(16'hFFFF, PFX_RANDOM, 1'b1, 1'b0);
      send_frame(2, PFX_RC, 1'b1, 1'b0);
      send_req(ACT_READ, 8'hFF, RIDX_W'(0));
      send_req(ACT_READ, 8'h00, RIDX_W'(1));
      send_frame(1, PFX_RANDOM, 1'b0, 1'b0);
      send_req(ACT_RX, 8'h00, {RIDX_W{1'b1}});
      send_frame(STORE_DEPTH + 1, PFX_RANDOM, 1'b1, 1'b0);

      // full-depth frame fills the whole payload store
      send_frame(STORE_DEPTH, PFX_RETURN, 1'b1, 1'b0);
      send_req(ACT_READ, 8'h00, {RIDX_W{1'b1}});
      run_traffic(70);

      write_reg(CSR_START_BYTE, 8'h00);
      write_reg(CSR_MAX_PAYLOAD, 0);
      run_traffic(50);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_reg(CSR_START_BYTE, 8'hFF);
      write_reg(CSR_MAX_PAYLOAD, STORE_DEPTH);
      run_traffic(90);

      req_idle_pct = 10;
      rsp_idle_pct = 10;
      write_reg(CSR_START_BYTE, $urandom_range(0, 255));
      write_reg(CSR_MAX_PAYLOAD, $urandom_range(1, 64));
      run_traffic(30);
      hold_left = 200;
      run_traffic(60);

      write_reg(CSR_START_BYTE, START_BYTE_RST);
      write_reg(CSR_MAX_PAYLOAD, STORE_DEPTH - 1);
      run_traffic(50);

      drain();
      repeat (10) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending_rsp.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
